FILE: rtl/core/fdl_pkg.sv
package fdl_pkg;

  // storage and field widths
  localparam int MAX_LENGTH = 65536;
  localparam int MIN_LENGTH = 4;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 24;
  localparam int FRAC_W     = 16;
  localparam int DELAY_W    = 32;
  localparam int ACTION_W   = 2;

  typedef logic [ACTION_W-1:0]        action_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [DELAY_W-1:0]         delay_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  // action codes
  localparam action_t ACT_WRITE   = 2'd0;
  localparam action_t ACT_NEAREST = 2'd1;
  localparam action_t ACT_CUBIC   = 2'd2;

  // divide-by-three helpers for the coefficient numerators
  localparam int RECIP3      = 43691;  // ceil(2^17 / 3)
  localparam int THIRD_D     = 21845;  // (D - 1) / 3
  localparam int THIRD_2D    = 43690;  // (2D - 2) / 3
  localparam int THIRD_D_UP  = 21846;  // (D + 2) / 3

endpackage

FILE: rtl/core/fdl_ifs.sv
interface fdl_cmd_if;
  import fdl_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  sample_t sample_in;
  delay_t  delay_amount;

  modport source (output valid, action, sample_in, delay_amount, input ready);
  modport sink   (input valid, action, sample_in, delay_amount, output ready);
endinterface

interface fdl_res_if;
  import fdl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    held;

  modport source (output valid, sample_out, held, input ready);
  modport sink   (input valid, sample_out, held, output ready);
endinterface

FILE: rtl/core/fractional_delay_line.sv
// fractional delay line with nearest and cubic lagrange reads
//
// cmd channel (valid/ready): one transaction carries action, sample_in and
// delay_amount. a write stores sample_in at the write pointer and gives no
// result; a read gives exactly one transaction on the res channel
// (sample_out, held). unused action codes are taken and dropped.
// cfg_write/cfg_data set the line length (clamped to 4..65536) and clear the
// line; the user must write them only while no transaction is in flight, as
// the block itself does not enforce this. a write leaves cmd ready; a held
// read is answered from the check state, a nearest or cubic read passes the
// check, wrap and calc states; cmd is ready again the cycle after the output
// register is loaded. a cubic read uses the single shared multiplier for
// one reciprocal product, two products per coefficient and four
// multiply-accumulates; the four neighbour reads go through the one read
// port of the sample store during the reciprocal and coefficient products.
// reset and a length write clear pointer and last output; the store is not
// swept, a fill count marks which entries hold written samples and the rest
// read as zero, so the block is ready as soon as reset is released.
// a result waits in the output register while res is stalled; the block
// still takes writes meanwhile and stops only at the end of the next read.
module fractional_delay_line (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  fdl_pkg::len_t  cfg_data,
  fdl_cmd_if.sink        cmd,
  fdl_res_if.source      res
);
  import fdl_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WRAP  = 2'd2;
  localparam logic [1:0] ST_CALC  = 2'd3;

  localparam logic [3:0] STEP_NEAR = 4'd1;
  localparam logic [3:0] STEP_LAST = 4'd15;

  // control state
  logic [1:0] state;
  logic [3:0] step;
  len_t       len;
  addr_t      wp;
  len_t       fill;
  sample_t    last_output;
  logic       out_valid;

  // item payload and datapath registers
  action_t              act;
  delay_t               delay;
  logic signed [33:0]   diff;
  addr_t                idx;
  logic [FRAC_W-1:0]    u;
  logic [15:0]          uq;
  sample_t              x0, x1, x2, x3;
  logic signed [31:0]   c0, c1, c2, c3;
  logic signed [61:0]   prod;
  logic signed [56:0]   acc;
  sample_t              out_sample;
  logic                 out_held;

  // sample store, one write port and one registered read port
  sample_t store [MAX_LENGTH];
  sample_t rd_data;
  logic    rd_ok;

  // ---------------------------------------------------------------------------
  // handshake and control terms
  // ---------------------------------------------------------------------------
  logic  out_free;
  logic  cmd_take;
  logic  mem_we;
  logic  final_step;
  logic  held_done;
  logic  calc_done;
  len_t  cfg_len;
  len_t  wp_inc;

  assign cmd.ready  = (state == ST_IDLE) && !cfg_write;
  assign res.valid  = out_valid;
  assign res.sample_out = out_sample;
  assign res.held   = out_held;

  assign out_free   = !out_valid || res.ready;
  assign cmd_take   = cmd.valid && cmd.ready;
  assign mem_we     = cmd_take && (cmd.action == ACT_WRITE);
  assign final_step = (step == STEP_LAST) || ((act == ACT_NEAREST) && (step == STEP_NEAR));

  // ---------------------------------------------------------------------------
  // position: pointer minus delay, wrapped by the span of the line
  // ---------------------------------------------------------------------------
  logic [32:0]        span;
  logic               held_hit;
  logic signed [33:0] diff_w;
  logic signed [33:0] pos_w;

  assign span     = {len, {FRAC_W{1'b0}}};
  assign held_hit = ({1'b0, delay} >= span);
  assign diff_w   = $signed({2'b00, wp, {FRAC_W{1'b0}}}) - $signed({2'b00, delay});
  assign pos_w    = diff[33] ? (diff + $signed({1'b0, span})) : diff;

  assign held_done = (state == ST_CHECK) && held_hit && out_free;
  assign calc_done = (state == ST_CALC) && final_step && out_free;

  always_comb begin
    if (cfg_data < LEN_W'(MIN_LENGTH)) begin
      cfg_len = LEN_W'(MIN_LENGTH);
    end else if (cfg_data > LEN_W'(MAX_LENGTH)) begin
      cfg_len = LEN_W'(MAX_LENGTH);
    end else begin
      cfg_len = cfg_data;
    end
  end

  assign wp_inc = {1'b0, wp} + LEN_W'(1);

  // ---------------------------------------------------------------------------
  // neighbour addresses with circular wrap
  // ---------------------------------------------------------------------------
  len_t  idx_ext, nxt1, nxt2;
  addr_t a_prev, a_next, a_next2, raddr;
  sample_t rd_word;

  assign idx_ext = {1'b0, idx};
  assign nxt1    = idx_ext + LEN_W'(1);
  assign nxt2    = idx_ext + LEN_W'(2);
  assign a_prev  = (idx == '0) ? ADDR_W'(len - LEN_W'(1)) : (idx - ADDR_W'(1));
  assign a_next  = (nxt1 == len) ? '0 : nxt1[ADDR_W-1:0];
  assign a_next2 = (nxt2 >= len) ? ADDR_W'(nxt2 - len) : nxt2[ADDR_W-1:0];

  always_comb begin
    if (act == ACT_NEAREST) begin
      raddr = idx;
    end else begin
      case (step)
        4'd0:    raddr = a_prev;
        4'd1:    raddr = idx;
        4'd2:    raddr = a_next;
        default: raddr = a_next2;
      endcase
    end
  end

  // entries beyond the fill count were never written since the last clear
  assign rd_word = rd_ok ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wp] <= cmd.sample_in;
    end
    rd_data <= store[raddr];
    rd_ok   <= ({1'b0, raddr} < fill);
  end

  // ---------------------------------------------------------------------------
  // coefficient factors
  // each numerator divided by three holds a factor of three: the factor
  // divisible by three is picked by u mod 3 and replaced by its exact third
  // ---------------------------------------------------------------------------
  logic [17:0]        three_uq, rem_w;
  logic [1:0]         rem;
  logic signed [18:0] u_w, nu_w, m_w, p_w, m2_w;
  logic signed [18:0] q_w, nq_w, qm_w, qm2_w, qp_w;
  logic signed [17:0] fac_u, fac_nu, fac_m, fac_p, fac_m2;
  logic signed [17:0] fac_q, fac_nq, fac_qm, fac_qm2, fac_qp;
  logic signed [17:0] f1, f2, f3;
  logic [1:0]         coef_k;

  assign three_uq = {1'b0, uq, 1'b0} + {2'b00, uq};
  assign rem_w    = {2'b00, u} - three_uq;
  assign rem      = rem_w[1:0];

  assign u_w   = $signed({3'b000, u});
  assign nu_w  = -u_w;
  assign m_w   = u_w - 19'sd65536;
  assign p_w   = u_w + 19'sd65536;
  assign m2_w  = u_w - 19'sd131072;
  assign q_w   = $signed({3'b000, uq});
  assign nq_w  = -q_w;
  assign qm_w  = q_w - 19'(THIRD_D);
  assign qm2_w = q_w - 19'(THIRD_2D);
  assign qp_w  = q_w + 19'(THIRD_D_UP);

  assign fac_u   = u_w[17:0];
  assign fac_nu  = nu_w[17:0];
  assign fac_m   = m_w[17:0];
  assign fac_p   = p_w[17:0];
  assign fac_m2  = m2_w[17:0];
  assign fac_q   = q_w[17:0];
  assign fac_nq  = nq_w[17:0];
  assign fac_qm  = qm_w[17:0];
  assign fac_qm2 = qm2_w[17:0];
  assign fac_qp  = qp_w[17:0];

  // steps 2..9 form coefficients 0..3, two steps each
  assign coef_k = 2'(step[3:1] - 3'd1);

  always_comb begin
    case (coef_k)
      2'd0: begin
        // -u(u-D)(u-2D) / 3
        case (rem)
          2'd1:    begin f1 = fac_nu; f2 = fac_qm; f3 = fac_m2;  end
          2'd2:    begin f1 = fac_nu; f2 = fac_m;  f3 = fac_qm2; end
          default: begin f1 = fac_nq; f2 = fac_m;  f3 = fac_m2;  end
        endcase
      end
      2'd1: begin
        // (u-D)(u+D)(u-2D)
        f1 = fac_m; f2 = fac_p; f3 = fac_m2;
      end
      2'd2: begin
        // -u(u+D)(u-2D)
        f1 = fac_nu; f2 = fac_p; f3 = fac_m2;
      end
      default: begin
        // u(u-D)(u+D) / 3
        case (rem)
          2'd1:    begin f1 = fac_u; f2 = fac_qm; f3 = fac_p;  end
          2'd2:    begin f1 = fac_u; f2 = fac_m;  f3 = fac_qp; end
          default: begin f1 = fac_q; f2 = fac_m;  f3 = fac_p;  end
        endcase
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared multiplier
  // ---------------------------------------------------------------------------
  logic signed [36:0] mul_a;
  logic signed [24:0] mul_b;

  always_comb begin
    case (step)
      4'd0: begin
        mul_a = {21'd0, u};
        mul_b = 25'(RECIP3);
      end
      4'd2, 4'd4, 4'd6, 4'd8: begin
        mul_a = 37'(f1);
        mul_b = 25'(f2);
      end
      4'd3, 4'd5, 4'd7, 4'd9: begin
        mul_a = 37'($signed(prod[35:0]));
        mul_b = 25'(f3);
      end
      4'd10: begin mul_a = 37'(c0); mul_b = 25'(x0); end
      4'd11: begin mul_a = 37'(c1); mul_b = 25'(x1); end
      4'd12: begin mul_a = 37'(c2); mul_b = 25'(x2); end
      4'd13: begin mul_a = 37'(c3); mul_b = 25'(x3); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // coefficient to q.30, rounding half up
  logic signed [51:0] cr_sum;
  logic signed [31:0] c_w;

  assign cr_sum = $signed(prod[51:0]) + 52'sd262144;
  assign c_w    = cr_sum[50:19];

  // accumulator from q.30 to a sample, rounding half up, then saturation
  logic signed [56:0] fin;
  logic signed [26:0] r_w;
  sample_t            sat_w;
  sample_t            result_w;

  assign fin = acc + 57'sd536870912;
  assign r_w = fin[56:30];

  always_comb begin
    if (r_w > 27'sd8388607) begin
      sat_w = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (r_w < -27'sd8388608) begin
      sat_w = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_w = r_w[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    if (state == ST_CHECK) begin
      result_w = last_output;
    end else if (act == ACT_NEAREST) begin
      result_w = rd_word;
    end else begin
      result_w = sat_w;
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      len         <= LEN_W'(MAX_LENGTH);
      wp          <= '0;
      fill        <= '0;
      last_output <= '0;
      out_valid   <= 1'b0;
    end else begin
      // a new result may replace one that leaves in the same cycle
      if (held_done || calc_done) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        len         <= cfg_len;
        wp          <= '0;
        fill        <= '0;
        last_output <= '0;
      end else if (mem_we) begin
        wp <= (wp_inc == len) ? '0 : wp_inc[ADDR_W-1:0];
        if (fill != len) begin
          fill <= fill + LEN_W'(1);
        end
      end

      case (state)
        ST_IDLE: begin
          if (cmd_take && (cmd.action == ACT_NEAREST || cmd.action == ACT_CUBIC)) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (held_hit) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          step  <= '0;
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (final_step) begin
            if (out_free) begin
              last_output <= result_w;
              state       <= ST_IDLE;
            end
          end else begin
            step <= step + 4'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (cmd_take) begin
      act   <= cmd.action;
      delay <= cmd.delay_amount;
    end

    if (state == ST_CHECK) begin
      diff <= diff_w;
    end

    if (state == ST_WRAP) begin
      idx <= pos_w[FRAC_W+ADDR_W-1:FRAC_W];
      u   <= pos_w[FRAC_W-1:0];
    end

    if (state == ST_CALC) begin
      case (step)
        4'd1: begin
          x0 <= rd_word;
          uq <= prod[32:17];
        end
        4'd2: x1 <= rd_word;
        4'd3: x2 <= rd_word;
        4'd4: begin
          x3 <= rd_word;
          c0 <= c_w;
        end
        4'd6:  c1 <= c_w;
        4'd8:  c2 <= c_w;
        4'd10: c3 <= c_w;
        4'd11: acc <= $signed(prod[56:0]);
        4'd12, 4'd13, 4'd14: acc <= acc + $signed(prod[56:0]);
        default: ;
      endcase
    end

    if (held_done || calc_done) begin
      out_sample <= result_w;
      out_held   <= held_done;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= len)
    else $error("fill count beyond line length");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst) {1'b0, wp} < len)
    else $error("write pointer beyond line length");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (wp == '0) && (fill == '0) && (last_output == '0))
    else $error("length write did not clear the line");

endmodule
